/* hdl/ttg_pkg.sv */
package ttg_pkg;

  localparam int HIST_DEPTH = 64;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int WIN_W      = 7;
  localparam int WIN_CW     = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int SUM_W      = 16 + HIST_AW;

  // shared restoring divider
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int Q_ONE     = 65536;
  localparam int Q_HALF    = 32768;
  localparam int PAUSE_MUL = 5000;
  localparam int EVICT_LIM = 196608;    // 0.3 * 10 * 65536
  localparam int PR_OFF    = 1966080;   // 0.3 * 100 * 65536
  localparam int PR_MUL    = 8259553;   // ceil(2^29 / 65)
  localparam int PR_SH     = 29;
  localparam int B_BASE    = 655360;
  localparam int B_MIN     = 32768;
  localparam int B_MUL     = 838861;    // ceil(2^23 / 10)
  localparam int B_SH      = 23;

  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_WARN  = 3'd0;
  localparam logic [2:0] REG_CRIT  = 3'd1;
  localparam logic [2:0] REG_EMERG = 3'd2;
  localparam logic [2:0] REG_FLOOR = 3'd3;
  localparam logic [2:0] REG_CEIL  = 3'd4;

  typedef struct packed {
    logic signed [15:0] warn;
    logic signed [15:0] crit;
    logic signed [15:0] emerg;
    logic [16:0]        floor_q;
    logic [16:0]        ceil_q;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul1;
    logic mul2;
    logic tdiv_start;
    logic thr_latch;
    logic adiv_start;
    logic avg_latch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic walk_done;
    logic n_zero;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [16:0]        throttle;
    logic [12:0]        pause_us;
    logic               needs_pause;
    logic               evict_flag;
    logic [16:0]        evict_pressure;
    logic [15:0]        batch_size;
    logic signed [15:0] peak_temp;
    logic signed [15:0] average_temp;
    logic               emergency;
  } res_t;

endpackage

/* hdl/ttg_if.sv */
interface ttg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic [15:0]        requested_batch;
  logic [6:0]         window_len;

  modport source (output valid, temperature, requested_batch, window_len, input ready);
  modport sink   (input valid, temperature, requested_batch, window_len, output ready);
endinterface

interface ttg_out_if;
  logic               valid;
  logic               ready;
  logic [16:0]        throttle;
  logic [12:0]        pause_us;
  logic               needs_pause;
  logic               evict_flag;
  logic [16:0]        evict_pressure;
  logic [15:0]        batch_size;
  logic signed [15:0] peak_temp;
  logic signed [15:0] average_temp;
  logic               emergency;

  modport source (output valid, throttle, pause_us, needs_pause, evict_flag, evict_pressure,
                  batch_size, peak_temp, average_temp, emergency, input ready);
  modport sink   (input valid, throttle, pause_us, needs_pause, evict_flag, evict_pressure,
                  batch_size, peak_temp, average_temp, emergency, output ready);
endinterface

/* hdl/thermal_throttle_governor.sv */
// Thermal throttle governor: each input transaction carries one junction
// temperature sample (signed, 1/16 degree C), a requested batch size and an
// averaging window; it produces exactly one result transaction with the Q16
// throttle, pause time, evict flags and pressure, scaled batch size, running
// peak, window average and the sticky emergency flag. Items are processed one
// at a time. The time per item is set by the 50-step shared divider for the
// throttle and the 1-entry-per-cycle walk of the history memory, which run
// side by side, then by the 22-step divide for the average, which is skipped
// for an empty window. A finished result sits in the output register, so the
// next sample can be taken while it waits. Thresholds and throttle limits
// live in APB registers at byte offsets 0x00..0x10 and may only be written
// while no transaction is in flight.
module thermal_throttle_governor (
  input  logic                        clk,
  input  logic                        rst_n,
  ttg_in_if.sink                      in_ch,
  ttg_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttg_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ttg_pkg::*;

  // configuration registers
  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn    <= 16'sd1360;
      cfg_r.crit    <= 16'sd1520;
      cfg_r.emerg   <= 16'sd1680;
      cfg_r.floor_q <= 17'd0;
      cfg_r.ceil_q  <= 17'd62259;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WARN:  cfg_r.warn    <= pwdata[15:0];
        REG_CRIT:  cfg_r.crit    <= pwdata[15:0];
        REG_EMERG: cfg_r.emerg   <= pwdata[15:0];
        REG_FLOOR: cfg_r.floor_q <= pwdata[16:0];
        REG_CEIL:  cfg_r.ceil_q  <= pwdata[16:0];
        default:   ;  // unmapped offset, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WARN:  prdata = {{16{cfg_r.warn[15]}}, cfg_r.warn};
      REG_CRIT:  prdata = {{16{cfg_r.crit[15]}}, cfg_r.crit};
      REG_EMERG: prdata = {{16{cfg_r.emerg[15]}}, cfg_r.emerg};
      REG_FLOOR: prdata = {15'b0, cfg_r.floor_q};
      REG_CEIL:  prdata = {15'b0, cfg_r.ceil_q};
      default:   prdata = '0;
    endcase
  end

  // controller / datapath
  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic out_valid;

  ttg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_temp   (in_ch.temperature),
    .in_req    (in_ch.requested_batch),
    .in_win    (in_ch.window_len),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .res       (res),
    .out_valid (out_valid)
  );

  // result transaction
  assign out_ch.valid          = out_valid;
  assign out_ch.throttle       = res.throttle;
  assign out_ch.pause_us       = res.pause_us;
  assign out_ch.needs_pause    = res.needs_pause;
  assign out_ch.evict_flag     = res.evict_flag;
  assign out_ch.evict_pressure = res.evict_pressure;
  assign out_ch.batch_size     = res.batch_size;
  assign out_ch.peak_temp      = res.peak_temp;
  assign out_ch.average_temp   = res.average_temp;
  assign out_ch.emergency      = res.emergency;
endmodule

/* hdl/ttg_div.sv */
module ttg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttg_pkg::DIV_NW-1:0]  num,
  input  logic [ttg_pkg::DIV_DW-1:0]  den,
  input  logic [ttg_pkg::DIV_CW-1:0]  nbits,
  output logic [ttg_pkg::DIV_NW-1:0]  quo,
  output logic                        busy
);
  import ttg_pkg::*;

  logic [DIV_NW-1:0] n_r, q_r;
  logic [DIV_DW-1:0] rem_r, den_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  always_comb begin
    trial   = {rem_r, n_r[DIV_NW-1]};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= (nbits != '0);
      cnt_r  <= nbits;
      n_r    <= num;
      den_r  <= den;
      q_r    <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      n_r    <= {n_r[DIV_NW-2:0], 1'b0};
      q_r    <= {q_r[DIV_NW-2:0], fits};
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != DIV_CW'(1));
    end
  end

  assign quo  = q_r;
  assign busy = busy_r;
endmodule

/* hdl/ttg_dp.sv */
module ttg_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ttg_pkg::cmd_t      cmd,
  input  ttg_pkg::cfg_t      cfg,
  input  logic signed [15:0] in_temp,
  input  logic [15:0]        in_req,
  input  logic [6:0]         in_win,
  input  logic               out_ready,
  output ttg_pkg::sts_t      sts,
  output ttg_pkg::res_t      res,
  output logic               out_valid
);
  import ttg_pkg::*;

  typedef enum logic [1:0] {M_FLOOR, M_CEIL, M_LIN, M_QUAD} mode_t;

  function automatic logic [16:0] sat_q16(input logic signed [51:0] v);
    logic [16:0] r;
    if (v < 0) r = '0;
    else if (v > 52'sd65536) r = 17'(Q_ONE);
    else r = v[16:0];
    return r;
  endfunction

  // sample state
  logic signed [15:0] ring_mem [HIST_DEPTH];
  logic [HIST_AW-1:0] wp_r, wp_nxt, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, n_nxt, n_r, rd_left_r;
  logic signed [15:0] peak_r, temp_r, rdata_r;
  logic               emerg_r, rd_pend_r;
  logic [15:0]        req_r;
  logic signed [SUM_W-1:0] sum_r;

  always_comb begin
    wp_nxt  = (wp_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    cnt_nxt = (cnt_r == CNT_W'(HIST_DEPTH)) ? cnt_r : cnt_r + 1'b1;
    n_nxt   = (WIN_CW'(in_win) < WIN_CW'(cnt_nxt)) ? CNT_W'(in_win) : cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) ring_mem[wp_r] <= in_temp;
    if (!cmd.load && rd_left_r != '0) rdata_r <= ring_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      cnt_r     <= '0;
      peak_r    <= '0;
      emerg_r   <= 1'b0;
      rd_left_r <= '0;
      rd_pend_r <= 1'b0;
    end else if (cmd.load) begin
      wp_r      <= wp_nxt;
      cnt_r     <= cnt_nxt;
      if (in_temp > peak_r) peak_r <= in_temp;
      if (in_temp >= cfg.emerg) emerg_r <= 1'b1;
      rd_ptr_r  <= wp_r;
      rd_left_r <= n_nxt;
      rd_pend_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      rd_pend_r <= (rd_left_r != '0);
      if (rd_left_r != '0) begin
        rd_left_r <= rd_left_r - 1'b1;
        rd_ptr_r  <= (rd_ptr_r == '0) ? HIST_AW'(HIST_DEPTH - 1) : rd_ptr_r - 1'b1;
      end
      if (rd_pend_r) sum_r <= sum_r + {{HIST_AW{rdata_r[15]}}, rdata_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_r <= in_temp;
      req_r  <= in_req;
      n_r    <= n_nxt;
    end
  end

  // throttle datapath
  mode_t              mode_r;
  logic [15:0]        d_r, s_r;
  logic signed [17:0] range_r;
  logic [31:0]        p1_r, den_r;
  logic signed [50:0] num_r;
  logic               num_neg_r, sum_neg_r;
  logic signed [16:0] sq, dq, sl, dl;
  logic [16:0]        thr_r, thr_nxt;

  always_comb begin
    sq = 17'(cfg.emerg) - 17'(cfg.crit);
    dq = 17'(temp_r) - 17'(cfg.crit);
    sl = 17'(cfg.crit) - 17'(cfg.warn);
    dl = 17'(temp_r) - 17'(cfg.warn);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      range_r <= $signed({1'b0, cfg.ceil_q}) - $signed({1'b0, cfg.floor_q});
      if (temp_r < cfg.warn) begin
        mode_r <= M_FLOOR;
      end else if (temp_r >= cfg.crit) begin
        mode_r <= (sq <= 0) ? M_CEIL : M_QUAD;
        d_r    <= dq[15:0];
        s_r    <= sq[15:0];
      end else begin
        mode_r <= M_LIN;
        d_r    <= dl[15:0];
        s_r    <= sl[15:0];
      end
    end
    if (cmd.mul1) begin
      if (mode_r == M_QUAD) begin
        p1_r  <= d_r * d_r;
        den_r <= s_r * s_r;
      end else begin
        p1_r  <= 32'(d_r);
        den_r <= {15'b0, s_r, 1'b0};
      end
    end
    if (cmd.mul2) num_r <= 51'(range_r) * 51'($signed({1'b0, p1_r}));
    if (cmd.tdiv_start) num_neg_r <= num_r[50];
    if (cmd.adiv_start) sum_neg_r <= sum_r[SUM_W-1];
  end

  // shared divider
  logic [DIV_NW-1:0] div_num, div_q;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_CW-1:0] div_bits;
  logic              div_busy;
  logic [50:0]       num_mag;
  logic [SUM_W-1:0]  sum_mag;

  always_comb begin
    num_mag = num_r[50] ? 51'(-num_r) : 51'(num_r);
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    if (cmd.adiv_start) begin
      div_num  = DIV_NW'(sum_mag) << (DIV_NW - SUM_W);
      div_den  = DIV_DW'(n_r);
      div_bits = DIV_CW'(SUM_W);
    end else begin
      div_num  = num_mag[DIV_NW-1:0];
      div_den  = den_r;
      div_bits = DIV_CW'(DIV_NW);
    end
  end

  ttg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.tdiv_start | cmd.adiv_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_bits),
    .quo   (div_q),
    .busy  (div_busy)
  );

  logic signed [51:0] q_s, thr_raw;
  always_comb begin
    q_s     = num_neg_r ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    thr_raw = $signed({35'b0, cfg.floor_q}) + q_s;
    case (mode_r)
      M_FLOOR: thr_nxt = sat_q16($signed({35'b0, cfg.floor_q}));
      M_CEIL:  thr_nxt = sat_q16($signed({35'b0, cfg.ceil_q}));
      default: thr_nxt = sat_q16(thr_raw);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.thr_latch) thr_r <= thr_nxt;
  end

  // post pipeline, settles during states S_P1, S_P2 and S_P3 after the throttle latch
  logic [29:0]        pause_prod_r;
  logic [22:0]        pnum_r;
  logic [19:0]        f_r;
  logic [45:0]        pm_r;
  logic [35:0]        bp_r;
  logic [16:0]        press_r, pm_q;
  logic [15:0]        batch_r;
  logic [39:0]        bq;
  logic signed [21:0] fs;
  logic               evict;
  logic signed [15:0] avg_r;
  logic [SUM_W-1:0]   aq;

  always_comb begin
    evict = (21'(thr_r) * 21'd10) > 21'(EVICT_LIM);
    fs    = $signed(22'(B_BASE)) - $signed(22'(thr_r) * 22'd11);
    pm_q  = pm_r[PR_SH+16:PR_SH];
    bq    = bp_r[35:16] * 20'(B_MUL);
    aq    = sum_neg_r ? SUM_W'(-div_q[SUM_W-1:0]) : div_q[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    pause_prod_r <= 30'(thr_r) * 30'(PAUSE_MUL);
    pnum_r       <= evict ? 23'(24'(thr_r) * 24'd100 - 24'(PR_OFF)) : '0;
    f_r          <= (fs < $signed(22'(B_MIN))) ? 20'(B_MIN) : fs[19:0];
    pm_r         <= pnum_r * 23'(PR_MUL);
    bp_r         <= req_r * f_r;
    press_r      <= (pm_q > 17'(Q_ONE)) ? 17'(Q_ONE) : pm_q;
    if (thr_r == '0) batch_r <= req_r;
    else if (bq[B_SH+16:B_SH] == '0) batch_r <= 16'd1;
    else batch_r <= bq[B_SH+15:B_SH];
    if (cmd.avg_latch) avg_r <= (n_r == '0) ? 16'sd0 : aq[15:0];
  end

  // output register
  res_t res_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      res_r.throttle       <= thr_r;
      res_r.pause_us       <= pause_prod_r[28:16];
      res_r.needs_pause    <= (thr_r > 17'(Q_HALF));
      res_r.evict_flag     <= evict;
      res_r.evict_pressure <= press_r;
      res_r.batch_size     <= batch_r;
      res_r.peak_temp      <= peak_r;
      res_r.average_temp   <= avg_r;
      res_r.emergency      <= emerg_r;
    end
  end

  assign res       = res_r;
  assign out_valid = out_valid_r;

  assign sts.div_busy  = div_busy;
  assign sts.walk_done = (rd_left_r == '0) && !rd_pend_r;
  assign sts.n_zero    = (n_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;
endmodule

/* hdl/ttg_ctrl.sv */
module ttg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ttg_pkg::sts_t sts,
  output ttg_pkg::cmd_t cmd
);
  import ttg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL1, S_MUL2, S_TDIV, S_TWAIT, S_THR,
    S_P1, S_P2, S_P3, S_WALK, S_ASTART, S_AWAIT, S_AVG, S_OUT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_PREP;
        S_PREP:   state_r <= S_MUL1;
        S_MUL1:   state_r <= S_MUL2;
        S_MUL2:   state_r <= S_TDIV;
        S_TDIV:   state_r <= S_TWAIT;
        S_TWAIT:  if (!sts.div_busy) state_r <= S_THR;
        S_THR:    state_r <= S_P1;
        S_P1:     state_r <= S_P2;
        S_P2:     state_r <= S_P3;
        S_P3:     state_r <= S_WALK;
        S_WALK:   if (sts.walk_done) state_r <= sts.n_zero ? S_AVG : S_ASTART;
        S_ASTART: state_r <= S_AWAIT;
        S_AWAIT:  if (!sts.div_busy) state_r <= S_AVG;
        S_AVG:    state_r <= S_OUT;
        S_OUT:    if (sts.out_free) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cmd.load       = in_valid && (state_r == S_IDLE);
  assign cmd.prep       = (state_r == S_PREP);
  assign cmd.mul1       = (state_r == S_MUL1);
  assign cmd.mul2       = (state_r == S_MUL2);
  assign cmd.tdiv_start = (state_r == S_TDIV);
  assign cmd.thr_latch  = (state_r == S_THR);
  assign cmd.adiv_start = (state_r == S_ASTART);
  assign cmd.avg_latch  = (state_r == S_AVG);
  assign cmd.out_load   = (state_r == S_OUT) && sts.out_free;
endmodule

/* tb/thermal_throttle_governor_test.sv */
`timescale 1ns / 1ps

module thermal_throttle_governor_test;
  import ttg_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [15:0]        requested_batch;
    logic [6:0]         window_len;
  } sample_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ttg_in_if  in_ch ();
  ttg_out_if out_ch ();

  thermal_throttle_governor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state, mirrors the block's registers
  logic signed [15:0] gov_warn, gov_crit, gov_emerg;
  logic [16:0]        gov_floor, gov_ceil;
  logic signed [15:0] hist_ring [HIST_DEPTH];
  int                 hist_wp, hist_cnt;
  logic signed [15:0] peak_q;
  logic               emerg_latch;

  sample_t pending_samples[$];
  res_t    expected_results[$];
  int      mismatch_count;
  int      idle_cycles;
  int      in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic longint sat_q16(input longint v);
    if (v < 0) return 0;
    if (v > Q_ONE) return Q_ONE;
    return v;
  endfunction

  function automatic longint throttle_for(input int t);
    longint range, s, d;
    range = longint'(gov_ceil) - longint'(gov_floor);
    if (t < gov_warn) return sat_q16(gov_floor);
    if (t >= gov_crit) begin
      s = longint'(gov_emerg) - gov_crit;
      d = longint'(t) - gov_crit;
      if (s <= 0) return sat_q16(gov_ceil);
      return sat_q16(longint'(gov_floor) + (range * d * d) / (s * s));
    end
    s = longint'(gov_crit) - gov_warn;
    d = longint'(t) - gov_warn;
    return sat_q16(longint'(gov_floor) + (range * d) / (2 * s));
  endfunction

  // advance the predictor by one sample and queue the expected result
  task automatic predict_result(input sample_t smp);
    res_t   r;
    longint thr, pressure, f, sum, batch;
    int     n, t;
    t = smp.temperature;
    if (smp.temperature > peak_q) peak_q = smp.temperature;
    hist_ring[hist_wp] = smp.temperature;
    hist_wp = (hist_wp + 1) % HIST_DEPTH;
    if (hist_cnt < HIST_DEPTH) hist_cnt++;
    thr = throttle_for(t);
    if (smp.temperature >= gov_emerg) emerg_latch = 1'b1;
    r = '0;
    r.throttle = thr[16:0];
    r.pause_us = 13'((thr * 5000) / Q_ONE);
    r.needs_pause = thr > Q_HALF;
    r.evict_flag = (10 * thr) > (3 * Q_ONE);
    pressure = 0;
    if (r.evict_flag) begin
      pressure = (100 * thr - 1966080) / 65;
      if (pressure > Q_ONE) pressure = Q_ONE;
    end
    r.evict_pressure = pressure[16:0];
    if (thr <= 0) batch = smp.requested_batch;
    else begin
      f = 655360 - 11 * thr;
      if (f < 32768) f = 32768;
      batch = (longint'(smp.requested_batch) * f) / 655360;
      if (batch < 1) batch = 1;
    end
    r.batch_size = batch[15:0];
    r.peak_temp = peak_q;
    n = (smp.window_len < hist_cnt) ? smp.window_len : hist_cnt;
    sum = 0;
    for (int i = 0; i < n; i++)
      sum += hist_ring[(hist_wp + HIST_DEPTH - 1 - i) % HIST_DEPTH];
    r.average_temp = (n > 0) ? 16'(sum / n) : 16'sd0;
    r.emergency = emerg_latch;
    expected_results.push_back(r);
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // driver: feeds pending samples, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_result('{in_ch.temperature,
          in_ch.requested_batch, in_ch.window_len});
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.temperature <= s.temperature;
          in_ch.requested_batch <= s.requested_batch;
          in_ch.window_len <= s.window_len;
          in_gap <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, throttle", out_ch.throttle, -1);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_ch.throttle !== e.throttle)
            report_mismatch("throttle", out_ch.throttle, e.throttle);
          if (out_ch.pause_us !== e.pause_us)
            report_mismatch("pause_us", out_ch.pause_us, e.pause_us);
          if (out_ch.needs_pause !== e.needs_pause)
            report_mismatch("needs_pause", out_ch.needs_pause, e.needs_pause);
          if (out_ch.evict_flag !== e.evict_flag)
            report_mismatch("evict_flag", out_ch.evict_flag, e.evict_flag);
          if (out_ch.evict_pressure !== e.evict_pressure)
            report_mismatch("evict_pressure", out_ch.evict_pressure, e.evict_pressure);
          if (out_ch.batch_size !== e.batch_size)
            report_mismatch("batch_size", out_ch.batch_size, e.batch_size);
          if (out_ch.peak_temp !== e.peak_temp)
            report_mismatch("peak_temp", out_ch.peak_temp, e.peak_temp);
          if (out_ch.average_temp !== e.average_temp)
            report_mismatch("average_temp", out_ch.average_temp, e.average_temp);
          if (out_ch.emergency !== e.emergency)
            report_mismatch("emergency", out_ch.emergency, e.emergency);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) out_gap <= pick_gap();
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("thermal_throttle_governor_test NOT OK");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WARN:  gov_warn  = value[15:0];
      REG_CRIT:  gov_crit  = value[15:0];
      REG_EMERG: gov_emerg = value[15:0];
      REG_FLOOR: gov_floor = value[16:0];
      REG_CEIL:  gov_ceil  = value[16:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int w, input int c, input int e,
                                input int fl, input int ce);
    cfg_write(REG_WARN, 32'(w));
    cfg_write(REG_CRIT, 32'(c));
    cfg_write(REG_EMERG, 32'(e));
    cfg_write(REG_FLOOR, 32'(fl));
    cfg_write(REG_CEIL, 32'(ce));
  endtask

  // wait for the block to drain before touching registers
  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(input int lo, input int hi);
    sample_t s;
    int wsel;
    s.temperature = 16'($signed($urandom_range(0, hi - lo)) + lo);
    s.requested_batch = ($urandom_range(0, 7) == 0) ?
        (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0) : 16'($urandom);
    wsel = $urandom_range(0, 9);
    s.window_len = (wsel == 0) ? 7'd0 : (wsel == 1) ? 7'd64 :
                   (wsel == 2) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(1, 64));
    return s;
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      // mostly around the thresholds, sometimes across -2048 to 32767
      if ($urandom_range(0, 3) == 0)
        pending_samples.push_back(rand_sample(-2048, 32767));
      else
        pending_samples.push_back(rand_sample(int'(gov_warn) - 300, int'(gov_emerg) + 300));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.temperature = '0; in_ch.requested_batch = '0;
    in_ch.window_len = '0; out_ch.ready = 1'b0;
    mismatch_count = 0; idle_cycles = 0; in_gap = 0; out_gap = 0;
    gov_warn = 16'sd1360; gov_crit = 16'sd1520; gov_emerg = 16'sd1680;
    gov_floor = 17'd0; gov_ceil = 17'd62259;
    for (int i = 0; i < HIST_DEPTH; i++) hist_ring[i] = '0;
    hist_wp = 0; hist_cnt = 0; peak_q = '0; emerg_latch = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes and the special cases
    pending_samples.push_back('{16'sd0, 16'd0, 7'd0});
    pending_samples.push_back('{-16'sd2048, 16'hFFFF, 7'd127});
    pending_samples.push_back('{16'sd1359, 16'd1000, 7'd1});
    pending_samples.push_back('{16'sd1360, 16'd0, 7'd2});
    pending_samples.push_back('{16'sd1440, 16'hFFFF, 7'd64});
    pending_samples.push_back('{16'sd1519, 16'd1, 7'd3});
    pending_samples.push_back('{16'sd1520, 16'd500, 7'd5});
    pending_samples.push_back('{16'sd1600, 16'd0, 7'd65});
    pending_samples.push_back('{16'sd1679, 16'hFFFF, 7'd10});
    pending_samples.push_back('{16'sd1680, 16'd1, 7'd64});
    pending_samples.push_back('{16'sd32767, 16'h5555, 7'h2A});
    pending_samples.push_back('{-16'sd1, 16'hAAAA, 7'h55});
    queue_random(150);
    wait_idle();

    // floor and ceiling beyond full scale, ceiling below floor
    set_thresholds(-2048, 0, 32767, 65536, 131071);
    pending_samples.push_back('{-16'sd2048, 16'd7, 7'd4});
    pending_samples.push_back('{16'sd32767, 16'd7, 7'd4});
    queue_random(120);
    wait_idle();
    set_thresholds(100, 200, 150, 90000, 20000);
    pending_samples.push_back('{16'sd250, 16'd9, 7'd1});
    queue_random(120);
    wait_idle();

    // emergency equal to critical, full-scale floor and ceiling
    set_thresholds(32765, 32766, 32766, 131071, 65536);
    pending_samples.push_back('{16'sd32766, 16'd3, 7'd64});
    queue_random(100);
    wait_idle();
    set_thresholds(0, 1, 32767, 0, 65536);
    queue_random(120);
    wait_idle();
    set_thresholds(-500, 400, 2000, 3000, 60000);
    queue_random(130);

    wait_idle();
    if (mismatch_count == 0)
      $display("thermal_throttle_governor_test OK");
    else
      $display("thermal_throttle_governor_test NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hdl/ttg_pkg.sv
hdl/ttg_if.sv
hdl/ttg_div.sv
hdl/ttg_dp.sv
hdl/ttg_ctrl.sv
hdl/thermal_throttle_governor.sv
tb/thermal_throttle_governor_test.sv
